FILE: src/mlb_pkg.sv
// Shared types and constants for the 2D bilinear map lookup.
// No dependencies.
package mlb_pkg;

   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_WR_X   = 2'd1,
      MODE_WR_Y   = 2'd2,
      MODE_WR_CELL = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_XSCAN,
      ST_YSCAN,
      ST_XDIV,
      ST_YDIV,
      ST_C11,
      ST_C12,
      ST_C21,
      ST_C22,
      ST_B1,
      ST_B2,
      ST_B3,
      ST_DONE
   } state_type;

   localparam int unsigned FRAC_BITS = 16;
   localparam logic CSR_X_USED = 1'b0;
   localparam logic CSR_Y_USED = 1'b1;

endpackage

FILE: src/mlb_divider.sv
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
// Depends on mlb_pkg.
module mlb_divider #(
   parameter int unsigned WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [WIDTH-1:0]                   num,
   input  logic [WIDTH-1:0]                   den,
   output logic                               done,
   output logic [mlb_pkg::FRAC_BITS:0]        quotient
);
   import mlb_pkg::*;

   localparam int unsigned QW = FRAC_BITS + 1;
   localparam int unsigned RW = WIDTH + 1;
   localparam int unsigned CW = $clog2(QW + 1);

   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] trial;

   // num <= den always (clamped q within interval), so 17 quotient bits suffice
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[RW-2:0], 1'b0};
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         quo_in  = '0;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == CW'(QW)) begin
            // first step: quotient bit for num itself (1 only when num equals den)
            trial = rem_ff;
         end
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0 || $past(start) == 1'b0) else $error("count");

endmodule

FILE: src/map_lookup_2d_bilinear_core.sv
// 2D bilinear map lookup: breakpoint/cell stores, sequencer, shared divider
// and shared multiplier. Depends on mlb_pkg and mlb_divider.
// Writes (modes 1..3) leave busy low: one write a cycle, taken only while no
// lookup holds busy. A lookup scans the x then the y breakpoints, one interval
// at a time (read, then compare), runs the x and then the y divide, then reads
// the cells and blends. rsp_valid strobes in the same cycle that busy drops
// and the next beat is accepted in that cycle.
// Synchronous reset clears control and sets both sizes to 16.
module map_lookup_2d_bilinear_core #(
   parameter int unsigned MAX_X_POINTS    = 16,
   parameter int unsigned MAX_Y_POINTS    = 16,
   parameter int unsigned BREAKPOINT_BITS = 16,
   parameter int unsigned CELL_BITS       = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_mode,
   input  logic [3:0]          req_row,
   input  logic [3:0]          req_column,
   input  logic [15:0]         req_breakpoint_value,
   input  logic signed [15:0]  req_cell_value,
   input  logic [15:0]         req_x_query,
   input  logic [15:0]         req_y_query,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_interpolated,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [4:0]          csr_data
);
   import mlb_pkg::*;

   localparam int unsigned BW  = BREAKPOINT_BITS;
   localparam int unsigned CB  = CELL_BITS;
   localparam int unsigned XAW = $clog2(MAX_X_POINTS);
   localparam int unsigned YAW = $clog2(MAX_Y_POINTS);
   localparam int unsigned NCELL = MAX_X_POINTS * MAX_Y_POINTS;
   localparam int unsigned CAW = $clog2(NCELL);
   localparam int unsigned RW  = FRAC_BITS + 1;
   localparam int unsigned DW  = CB + 2;        // blend difference width
   localparam int unsigned PW  = DW + RW + 1;   // product width
   localparam int unsigned XNW = $clog2(MAX_X_POINTS + 1);
   localparam int unsigned YNW = $clog2(MAX_Y_POINTS + 1);

   // stores
   logic [BW-1:0] xbp_mem [MAX_X_POINTS];
   logic [BW-1:0] ybp_mem [MAX_Y_POINTS];
   logic [CB-1:0] cell_mem [NCELL];

   logic [4:0] xused_ff, yused_ff;
   state_type  state_ff, state_in;

   logic [BW-1:0] xq_ff, xq_in, yq_ff, yq_in;
   logic [XAW-1:0] xi_ff, xi_in;
   logic [YAW-1:0] yi_ff, yi_in;
   logic           xfound_ff, xfound_in, yfound_ff, yfound_in;
   logic [BW-1:0]  num_ff, num_in, den_ff, den_in;
   logic [RW-1:0]  xr_ff, xr_in, yr_ff, yr_in;
   logic [XNW-1:0] nx;
   logic [YNW-1:0] ny;

   logic signed [CB-1:0] c11_ff, c12_ff, c21_ff, c22_ff, z1_ff, z2_ff, cdata_ff;
   logic signed [CB-1:0] c11_in, c12_in, c21_in, c22_in, z1_in, z2_in;
   logic [CAW-1:0] caddr;
   logic [3:0]     sub_ff, sub_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_data_ff, rsp_data_in;

   // scan pointer / reads
   logic [BW-1:0] xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic [XAW-1:0] xrd;
   logic [YAW-1:0] yrd;

   logic div_start, div_done;
   logic [RW-1:0] div_q;

   // shared multiplier (one per cycle, registered)
   logic signed [DW-1:0] mul_a;
   logic signed [RW:0]   mul_b;
   logic signed [PW-1:0] prod_ff;
   logic signed [CB-1:0] base_ff, base_in;

   mlb_divider #(.WIDTH(BW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(num_ff), .den(den_ff), .done(div_done), .quotient(div_q));

   function automatic logic [5:0] clamp_size(input logic [4:0] r, input int unsigned mx);
      logic [5:0] v;
      v = {1'b0, r};
      if (r < 5'd2) v = 6'd2;
      else if (32'(r) > mx) v = 6'(mx);
      return v;
   endfunction

   assign nx = XNW'(clamp_size(xused_ff, MAX_X_POINTS));
   assign ny = YNW'(clamp_size(yused_ff, MAX_Y_POINTS));

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         xused_ff <= 5'd16;
         yused_ff <= 5'd16;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_X_USED: xused_ff <= csr_data;
            CSR_Y_USED: yused_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // store writes and registered reads
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         if (req_mode == MODE_WR_X && 32'(req_row) < MAX_X_POINTS)
            xbp_mem[XAW'(req_row)] <= BW'(req_breakpoint_value);
         if (req_mode == MODE_WR_Y && 32'(req_column) < MAX_Y_POINTS)
            ybp_mem[YAW'(req_column)] <= BW'(req_breakpoint_value);
         if (req_mode == MODE_WR_CELL && 32'(req_row) < MAX_X_POINTS
             && 32'(req_column) < MAX_Y_POINTS)
            cell_mem[CAW'(32'(req_row) * MAX_Y_POINTS + 32'(req_column))]
               <= CB'(req_cell_value);
      end
      xlo_ff   <= xbp_mem[xrd];
      xhi_ff   <= xbp_mem[XAW'(32'(xrd) + 1 < MAX_X_POINTS ? 32'(xrd) + 1 : 0)];
      ylo_ff   <= ybp_mem[yrd];
      yhi_ff   <= ybp_mem[YAW'(32'(yrd) + 1 < MAX_Y_POINTS ? 32'(yrd) + 1 : 0)];
      cdata_ff <= cell_mem[caddr];
   end

   // first-end and last-end breakpoint reads for clamping, registered
   logic [BW-1:0] xfirst_ff, xlast_ff, yfirst_ff, ylast_ff;
   always_ff @(posedge clock) begin
      xfirst_ff <= xbp_mem[0];
      xlast_ff  <= xbp_mem[XAW'(nx - 1'b1)];
      yfirst_ff <= ybp_mem[0];
      ylast_ff  <= ybp_mem[YAW'(ny - 1'b1)];
   end

   // clamped queries
   logic [BW-1:0] xqc, yqc;
   always_comb begin
      xqc = xq_ff;
      if (xqc <= xfirst_ff) xqc = xfirst_ff;
      if (xqc >= xlast_ff)  xqc = xlast_ff;
      yqc = yq_ff;
      if (yqc <= yfirst_ff) yqc = yfirst_ff;
      if (yqc >= ylast_ff)  yqc = ylast_ff;
   end

   // blend helper: prod holds (b - a) * ratio
   logic signed [PW-1:0] fl;
   assign fl = prod_ff >>> FRAC_BITS;

   always_comb begin
      state_in     = state_ff;
      xq_in        = xq_ff;
      yq_in        = yq_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      xfound_in    = xfound_ff;
      yfound_in    = yfound_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      xr_in        = xr_ff;
      yr_in        = yr_ff;
      c11_in       = c11_ff;
      c12_in       = c12_ff;
      c21_in       = c21_ff;
      c22_in       = c22_ff;
      z1_in        = z1_ff;
      z2_in        = z2_ff;
      base_in      = base_ff;
      sub_in       = sub_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      xrd          = xi_ff;
      yrd          = yi_ff;
      caddr        = CAW'(32'(xi_ff) * MAX_Y_POINTS + 32'(yi_ff));
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_mode == MODE_LOOKUP) begin
               xq_in     = BW'(req_x_query);
               yq_in     = BW'(req_y_query);
               xi_in     = '0;
               yi_in     = '0;
               xfound_in = 1'b0;
               yfound_in = 1'b0;
               sub_in    = '0;
               state_in  = ST_XSCAN;
            end
         end
         // sub_ff 0: read issued; 1: compare. One interval per read/compare pair.
         ST_XSCAN: begin
            if (sub_ff == 4'd0) begin
               sub_in = 4'd1;
            end else begin
               sub_in = 4'd0;
               if (xqc >= xlo_ff && xqc <= xhi_ff) begin
                  xfound_in = 1'b1;
                  num_in    = xqc - xlo_ff;
                  den_in    = (xhi_ff > xlo_ff) ? xhi_ff - xlo_ff : '0;
                  state_in  = ST_YSCAN;
               end else if (32'(xi_ff) + 2 >= 32'(nx)) begin
                  xi_in    = '0;
                  den_in   = '0;
                  state_in = ST_YSCAN;
               end else begin
                  xi_in = xi_ff + 1'b1;
               end
            end
         end
         ST_YSCAN: begin
            if (sub_ff == 4'd0) begin
               sub_in = 4'd1;
            end else begin
               sub_in = 4'd0;
               if (den_ff != '0) begin
                  div_start = 1'b1;
               end
               if (yqc >= ylo_ff && yqc <= yhi_ff) begin
                  yfound_in = 1'b1;
                  state_in  = ST_XDIV;
               end else if (32'(yi_ff) + 2 >= 32'(ny)) begin
                  yi_in    = '0;
                  state_in = ST_XDIV;
               end else begin
                  yi_in = yi_ff + 1'b1;
                  state_in = ST_YSCAN;
               end
               // only launch the x divide once
               if (state_in == ST_YSCAN) div_start = 1'b0;
            end
         end
         ST_XDIV: begin
            if (den_ff == '0) begin
               xr_in = '0;
               sub_in = 4'd0;
               state_in = ST_YDIV;
            end else if (div_done) begin
               xr_in = div_q;
               sub_in = 4'd0;
               state_in = ST_YDIV;
            end
         end
         ST_YDIV: begin
            if (sub_ff == 4'd0) begin
               sub_in = 4'd1;
               yrd = yi_ff;
            end else if (sub_ff == 4'd1) begin
               if (yfound_ff && yhi_ff > ylo_ff) begin
                  num_in = yqc - ylo_ff;
                  den_in = yhi_ff - ylo_ff;
                  sub_in = 4'd2;
               end else begin
                  yr_in = '0;
                  state_in = ST_C11;
               end
            end else if (sub_ff == 4'd2) begin
               div_start = 1'b1;
               sub_in = 4'd3;
            end else if (div_done) begin
               yr_in = div_q;
               state_in = ST_C11;
            end
         end
         ST_C11: begin
            caddr = CAW'(32'(xi_ff) * MAX_Y_POINTS + 32'(yi_ff) + 1);
            c11_in = cdata_ff;
            state_in = ST_C12;
         end
         ST_C12: begin
            caddr = CAW'((32'(xi_ff) + 1) * MAX_Y_POINTS + 32'(yi_ff));
            c12_in = cdata_ff;
            state_in = ST_C21;
         end
         ST_C21: begin
            caddr = CAW'((32'(xi_ff) + 1) * MAX_Y_POINTS + 32'(yi_ff) + 1);
            c21_in = cdata_ff;
            state_in = ST_C22;
         end
         ST_C22: begin
            c22_in = cdata_ff;
            mul_a  = DW'(c12_ff) - DW'(c11_ff);
            mul_b  = $signed({1'b0, yr_ff});
            base_in = c11_ff;
            state_in = ST_B1;
         end
         ST_B1: begin
            z1_in  = CB'(fl + PW'(base_ff));
            mul_a  = DW'(c22_ff) - DW'(c21_ff);
            mul_b  = $signed({1'b0, yr_ff});
            base_in = c21_ff;
            state_in = ST_B2;
         end
         ST_B2: begin
            z2_in = CB'(fl + PW'(base_ff));
            mul_a = DW'(z2_in) - DW'(z1_ff);
            mul_b = $signed({1'b0, xr_ff});
            base_in = z1_ff;
            state_in = ST_B3;
         end
         ST_B3: begin
            rsp_data_in  = 16'(fl + PW'(base_ff));
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sub_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sub_ff       <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      xq_ff <= xq_in; yq_ff <= yq_in; xi_ff <= xi_in; yi_ff <= yi_in;
      xfound_ff <= xfound_in; yfound_ff <= yfound_in;
      num_ff <= num_in; den_ff <= den_in; xr_ff <= xr_in; yr_ff <= yr_in;
      c11_ff <= c11_in; c12_ff <= c12_in; c21_ff <= c21_in; c22_ff <= c22_in;
      z1_ff <= z1_in; z2_ff <= z2_in; base_ff <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interpolated = rsp_data_ff;

   a_rsp_after_blend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_B3) else $error("rsp without blend");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE) else $error("not idle after rsp");
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("double rsp");

endmodule
